// ===== rtl/wdsel_pkg.sv =====
// Shared types, widths and constants for the worker dispatch selector.
package wdsel_pkg;

  // Default table size and fixed field widths
  localparam int WORKERS_DEF = 16;
  localparam int ID_W        = 4;
  localparam int JOBS_W      = 16;
  localparam int TIME_W      = 20;
  localparam int POLICY_W    = 2;

  // Shared divider: 41-bit dividend covers 300 * 2^32, 21-bit divisor covers time + 1000
  localparam int DVD_W   = 41;
  localparam int DVS_W   = 21;
  localparam int QUO_W   = 32;
  localparam int SCORE_W = 34;
  localparam int TURN_W  = 32;

  // Weighted score constants, 32 fraction bits
  localparam logic [DVD_W-1:0]   SCORE_HALF      = 41'd2147483648;
  localparam logic [DVD_W-1:0]   SCORE_SPEED_NUM = 41'd1288490188800;
  localparam logic [SCORE_W-1:0] SCORE_HEALTH    = 34'd858993459;
  localparam logic [DVS_W-1:0]   TIME_BIAS       = 21'd1000;

  // Policy register codes (the unused code behaves as round robin)
  localparam logic [POLICY_W-1:0] POLICY_RR     = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_LEAST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WEIGHT = 2'd2;

  // Action codes of an input transaction
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_PICK   = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RR_SCAN,
    ST_SCAN,
    ST_LOAD,
    ST_DIV_J,
    ST_DIV_T,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic upd_we;     // write one table entry from the input ports
    logic pick_init;  // clear walk index, seen count, pick and have flag
    logic mod_start;  // divider: turn counter mod healthy count
    logic target_ld;  // capture remainder as round-robin target
    logic rr_step;    // round-robin walk over one entry
    logic turn_inc;   // advance turn counter
    logic ram_rd;     // read entry at walk index
    logic ll_cmp;     // least-loaded compare on read data
    logic j_start;    // divider: half / (jobs + 1)
    logic t_start;    // divider: speed numerator / (time + 1000)
    logic w_cmp;      // weighted score compare
    logic idx_inc;    // next entry
    logic out_load;   // capture result payload
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hcnt_zero;
    logic flag_at_idx;
    logic idx_last;
    logic rr_hit;
    logic div_done;
    logic div_busy;
  } sts_t;

endpackage

// ===== rtl/wdsel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wdsel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wdsel_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wdsel_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wdsel_pkg::DVD_W-1:0]   dividend,
  input  logic [wdsel_pkg::DVS_W-1:0]   divisor,
  output logic [wdsel_pkg::QUO_W-1:0]   quotient,
  output logic [wdsel_pkg::DVS_W-1:0]   remainder,
  output logic                          busy,
  output logic                          done
);

  localparam int DvdW = wdsel_pkg::DVD_W;
  localparam int DvsW = wdsel_pkg::DVS_W;
  localparam int QuoW = wdsel_pkg::QUO_W;
  localparam int CntW = $clog2(DvdW);

  logic [DvdW-1:0] dq_r,   dq_nxt;
  logic [DvsW-1:0] rem_r,  rem_nxt;
  logic [DvsW-1:0] dvs_r;
  logic [CntW-1:0] cnt_r,  cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DvsW:0]   rem_sh;
  logic [DvsW:0]   rem_sub;

  // One restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem_r, dq_r[DvdW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CntW'(DvdW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[DvsW-1:0];
        dq_nxt  = {dq_r[DvdW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DvsW-1:0];
        dq_nxt  = {dq_r[DvdW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient  = dq_r[QuoW-1:0];
  assign remainder = rem_r;
  assign busy      = busy_r;
  assign done      = done_r;

endmodule

// ===== rtl/wdsel_dp.sv =====
// Datapath: worker table, healthy count, turn counter, divider and best-so-far registers.
module wdsel_dp #(
  parameter int WORKERS = wdsel_pkg::WORKERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wdsel_pkg::cmd_t                cmd,
  output wdsel_pkg::sts_t                sts,
  input  logic [wdsel_pkg::ID_W-1:0]     in_worker_id,
  input  logic                           in_worker_healthy,
  input  logic [wdsel_pkg::JOBS_W-1:0]   in_active_jobs,
  input  logic [wdsel_pkg::TIME_W-1:0]   in_avg_time_ms,
  output logic                           out_found,
  output logic [wdsel_pkg::ID_W-1:0]     out_chosen_worker
);

  localparam int IdxW   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int CntW   = $clog2(WORKERS + 1);
  localparam int IdW    = wdsel_pkg::ID_W;
  localparam int JobsW  = wdsel_pkg::JOBS_W;
  localparam int TimeW  = wdsel_pkg::TIME_W;
  localparam int EntW   = JobsW + TimeW;
  localparam int DvdW   = wdsel_pkg::DVD_W;
  localparam int DvsW   = wdsel_pkg::DVS_W;
  localparam int QuoW   = wdsel_pkg::QUO_W;
  localparam int ScoreW = wdsel_pkg::SCORE_W;
  localparam int TurnW  = wdsel_pkg::TURN_W;

  logic [WORKERS-1:0] flags_r;
  logic [CntW-1:0]    hcnt_r;
  logic [TurnW-1:0]   turn_r;
  logic [IdxW-1:0]    idx_r;
  logic [CntW-1:0]    seen_r;
  logic [CntW-1:0]    target_r;
  logic [IdxW-1:0]    pick_r;
  logic               have_r;
  logic [JobsW-1:0]   best_jobs_r;
  logic [ScoreW-1:0]  best_score_r;
  logic [QuoW-1:0]    term_r;
  logic               found_r;
  logic [IdW-1:0]     chosen_r;

  logic               id_ok;
  logic               wr_en;
  logic [IdxW-1:0]    wr_idx;
  logic [EntW-1:0]    rd_ent;
  logic [JobsW-1:0]   rd_jobs;
  logic [TimeW-1:0]   rd_time;
  logic               flag_idx;
  logic               rr_hit;
  logic [DvdW-1:0]    div_dvd;
  logic [DvsW-1:0]    div_dvs;
  logic               div_start;
  logic [QuoW-1:0]    div_q;
  logic [DvsW-1:0]    div_rem;
  logic               div_busy;
  logic               div_done;
  logic [ScoreW-1:0]  score;

  // Update write decode: ids beyond the table are dropped
  assign id_ok  = (32'(in_worker_id) < WORKERS);
  assign wr_en  = cmd.upd_we && id_ok;
  assign wr_idx = IdxW'(in_worker_id);

  // Jobs and service time per worker
  wdsel_ram #(
    .WIDTH (EntW),
    .DEPTH (WORKERS)
  ) u_tbl (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata ({in_active_jobs, in_avg_time_ms}),
    .re    (cmd.ram_rd),
    .raddr (idx_r),
    .rdata (rd_ent)
  );

  assign rd_jobs = rd_ent[EntW-1:TimeW];
  assign rd_time = rd_ent[TimeW-1:0];

  // Healthy flags and a running count of them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      hcnt_r  <= '0;
    end else if (wr_en) begin
      flags_r[wr_idx] <= in_worker_healthy;
      hcnt_r <= hcnt_r - CntW'(flags_r[wr_idx]) + CntW'(in_worker_healthy);
    end
  end

  // Round-robin turn counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r <= '0;
    end else if (cmd.turn_inc) begin
      turn_r <= turn_r + TurnW'(1);
    end
  end

  // Divider operand select
  always_comb begin
    div_dvd = '0;
    div_dvs = '0;
    priority if (cmd.mod_start) begin
      div_dvd = DvdW'(turn_r);
      div_dvs = DvsW'(hcnt_r);
    end else if (cmd.j_start) begin
      div_dvd = wdsel_pkg::SCORE_HALF;
      div_dvs = DvsW'(rd_jobs) + DvsW'(1);
    end else if (cmd.t_start) begin
      div_dvd = wdsel_pkg::SCORE_SPEED_NUM;
      div_dvs = DvsW'(rd_time) + wdsel_pkg::TIME_BIAS;
    end else begin
      div_dvd = '0;
      div_dvs = '0;
    end
  end

  assign div_start = cmd.mod_start || cmd.j_start || cmd.t_start;

  wdsel_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .quotient  (div_q),
    .remainder (div_rem),
    .busy      (div_busy),
    .done      (div_done)
  );

  // Walk helpers
  assign flag_idx = flags_r[idx_r];
  assign rr_hit   = flag_idx && (seen_r == target_r);
  assign score    = ScoreW'(term_r) + ScoreW'(div_q) + wdsel_pkg::SCORE_HEALTH;

  // Walk index, round-robin position and best-so-far tracking
  always_ff @(posedge clk) begin
    if (cmd.pick_init) begin
      idx_r  <= '0;
      seen_r <= '0;
      pick_r <= '0;
      have_r <= 1'b0;
    end else begin
      if (cmd.idx_inc) begin
        idx_r <= idx_r + IdxW'(1);
      end
      if (cmd.rr_step) begin
        if (rr_hit) begin
          pick_r <= idx_r;
        end else if (flag_idx) begin
          seen_r <= seen_r + CntW'(1);
        end
      end
      if (cmd.ll_cmp && (!have_r || rd_jobs < best_jobs_r)) begin
        best_jobs_r <= rd_jobs;
        pick_r      <= idx_r;
        have_r      <= 1'b1;
      end
      if (cmd.w_cmp && (!have_r || score > best_score_r)) begin
        best_score_r <= score;
        pick_r       <= idx_r;
        have_r       <= 1'b1;
      end
    end
    if (cmd.target_ld) begin
      target_r <= CntW'(div_rem);
    end
    if (cmd.t_start) begin
      term_r <= div_q;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found_r  <= (hcnt_r != '0);
      chosen_r <= IdW'(pick_r);
    end
  end

  assign out_found         = found_r;
  assign out_chosen_worker = chosen_r;

  assign sts.hcnt_zero   = (hcnt_r == '0);
  assign sts.flag_at_idx = flag_idx;
  assign sts.idx_last    = (idx_r == IdxW'(WORKERS - 1));
  assign sts.rr_hit      = rr_hit;
  assign sts.div_done    = div_done;
  assign sts.div_busy    = div_busy;

endmodule

// ===== rtl/wdsel_ctrl.sv =====
// Controller: policy register, sequencing state machine and output handshake.
module wdsel_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_action,
  output logic                              in_stall,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              cfg_wr_en,
  input  logic [wdsel_pkg::POLICY_W-1:0]    cfg_wr_data,
  input  wdsel_pkg::sts_t                   sts,
  output wdsel_pkg::cmd_t                   cmd
);

  wdsel_pkg::state_t                  state_r, state_nxt;
  logic [wdsel_pkg::POLICY_W-1:0]     policy_r;
  logic                               out_valid_r, out_valid_nxt;
  logic                               accept;
  logic                               take_pick;
  logic                               out_free;
  logic                               pol_least;
  logic                               pol_weight;

  assign accept     = in_valid && (state_r == wdsel_pkg::ST_IDLE);
  assign take_pick  = accept && (in_action == wdsel_pkg::ACT_PICK);
  assign out_free   = !out_valid_r || !out_stall;
  assign pol_least  = (policy_r == wdsel_pkg::POLICY_LEAST);
  assign pol_weight = (policy_r == wdsel_pkg::POLICY_WEIGHT);

  // Policy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= wdsel_pkg::POLICY_RR;
    end else if (cfg_wr_en) begin
      policy_r <= cfg_wr_data;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wdsel_pkg::ST_IDLE: begin
        if (take_pick) begin
          priority if (sts.hcnt_zero) begin
            state_nxt = wdsel_pkg::ST_FINISH;
          end else if (pol_least || pol_weight) begin
            state_nxt = wdsel_pkg::ST_SCAN;
          end else begin
            state_nxt = wdsel_pkg::ST_MOD;
          end
        end
      end
      wdsel_pkg::ST_MOD: begin
        if (sts.div_done) begin
          state_nxt = wdsel_pkg::ST_RR_SCAN;
        end
      end
      wdsel_pkg::ST_RR_SCAN: begin
        if (sts.rr_hit) begin
          state_nxt = wdsel_pkg::ST_FINISH;
        end
      end
      wdsel_pkg::ST_SCAN: begin
        priority if (sts.flag_at_idx) begin
          state_nxt = wdsel_pkg::ST_LOAD;
        end else if (sts.idx_last) begin
          state_nxt = wdsel_pkg::ST_FINISH;
        end else begin
          state_nxt = wdsel_pkg::ST_SCAN;
        end
      end
      wdsel_pkg::ST_LOAD: begin
        priority if (pol_weight) begin
          state_nxt = wdsel_pkg::ST_DIV_J;
        end else if (sts.idx_last) begin
          state_nxt = wdsel_pkg::ST_FINISH;
        end else begin
          state_nxt = wdsel_pkg::ST_SCAN;
        end
      end
      wdsel_pkg::ST_DIV_J: begin
        if (sts.div_done) begin
          state_nxt = wdsel_pkg::ST_DIV_T;
        end
      end
      wdsel_pkg::ST_DIV_T: begin
        if (sts.div_done) begin
          state_nxt = sts.idx_last ? wdsel_pkg::ST_FINISH : wdsel_pkg::ST_SCAN;
        end
      end
      wdsel_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = wdsel_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wdsel_pkg::ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    cmd.upd_we    = accept && (in_action == wdsel_pkg::ACT_UPDATE);
    cmd.pick_init = take_pick;
    unique case (state_r)
      wdsel_pkg::ST_IDLE: begin
        cmd.mod_start = take_pick && !sts.hcnt_zero && !pol_least && !pol_weight;
      end
      wdsel_pkg::ST_MOD: begin
        cmd.target_ld = sts.div_done;
      end
      wdsel_pkg::ST_RR_SCAN: begin
        cmd.rr_step  = 1'b1;
        cmd.idx_inc  = !sts.rr_hit;
        cmd.turn_inc = sts.rr_hit;
      end
      wdsel_pkg::ST_SCAN: begin
        cmd.ram_rd  = sts.flag_at_idx;
        cmd.idx_inc = !sts.flag_at_idx && !sts.idx_last;
      end
      wdsel_pkg::ST_LOAD: begin
        cmd.ll_cmp  = !pol_weight;
        cmd.j_start = pol_weight;
        cmd.idx_inc = !pol_weight && !sts.idx_last;
      end
      wdsel_pkg::ST_DIV_J: begin
        cmd.t_start = sts.div_done;
      end
      wdsel_pkg::ST_DIV_T: begin
        cmd.w_cmp   = sts.div_done;
        cmd.idx_inc = sts.div_done && !sts.idx_last;
      end
      wdsel_pkg::ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // Result valid: set on load, cleared when the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wdsel_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != wdsel_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/worker_dispatch_selector_unit.sv =====
// Top level of the worker dispatch selector: controller, datapath and checks.
//
// Keeps a table of WORKERS entries (healthy flag, active jobs, average time)
// and answers pick requests under the policy register: round robin over the
// healthy workers in ascending id order, fewest active jobs, or highest
// weighted score (0.5/(1+jobs) + 0.3/(1+ms/1000) + 0.2, 32 fraction bits,
// ties to the lowest id). An update transaction gives no result; it is taken
// even while a result waits on the output. A pick with no healthy worker
// reports found 0. Round robin divides the turn counter by the healthy count,
// then walks the entries until the target is reached. Least loaded reads and
// compares each healthy entry and skips the unhealthy ones. Weighted makes
// two passes per healthy entry through the shared 41-step one-bit-per-cycle
// divider. Only one pick is worked on at a time; the table holds no
// clearing pass.
module worker_dispatch_selector_unit #(
  parameter int WORKERS = wdsel_pkg::WORKERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [wdsel_pkg::ID_W-1:0]        in_worker_id,
  input  logic                              in_worker_healthy,
  input  logic [wdsel_pkg::JOBS_W-1:0]      in_active_jobs,
  input  logic [wdsel_pkg::TIME_W-1:0]      in_avg_time_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [wdsel_pkg::ID_W-1:0]        out_chosen_worker,
  input  logic                              cfg_wr_en,
  input  logic [wdsel_pkg::POLICY_W-1:0]    cfg_wr_data
);

  wdsel_pkg::cmd_t cmd;
  wdsel_pkg::sts_t sts;

  // Sequencer
  wdsel_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_action   (in_action),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Table and arithmetic
  wdsel_dp #(
    .WORKERS (WORKERS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_worker_id      (in_worker_id),
    .in_worker_healthy (in_worker_healthy),
    .in_active_jobs    (in_active_jobs),
    .in_avg_time_ms    (in_avg_time_ms),
    .out_found         (out_found),
    .out_chosen_worker (out_chosen_worker)
  );

  // A result without a healthy worker always reports worker zero
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_chosen_worker == '0)
    else $error("result with found low carries a nonzero worker");

  // The shared divider is never restarted while it is still working
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_start || cmd.j_start || cmd.t_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // A new result appears only after the controller loaded the payload
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid rose without a payload load");

endmodule

// ===== test/tb.sv =====
// Testbench for worker_dispatch_selector_unit: directed and random table updates and picks.
`timescale 1ns / 100ps

module tb;

  localparam int POLICY_W = wdsel_pkg::POLICY_W;
  localparam int ID_W     = wdsel_pkg::ID_W;
  localparam int JOBS_W   = wdsel_pkg::JOBS_W;
  localparam int TIME_W   = wdsel_pkg::TIME_W;
  localparam int TURN_W   = wdsel_pkg::TURN_W;

  // Spare policy code, expected to act as round robin
  localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;
  localparam int NUM_WORKERS = wdsel_pkg::WORKERS_DEF;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 50;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] chosen;
  } pick_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_action = wdsel_pkg::ACT_UPDATE;
  logic [ID_W-1:0]     in_worker_id = '0;
  logic                in_worker_healthy = 1'b0;
  logic [JOBS_W-1:0]   in_active_jobs = '0;
  logic [TIME_W-1:0]   in_avg_time_ms = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_found;
  logic [ID_W-1:0]     out_chosen_worker;
  logic                cfg_wr_en = 1'b0;
  logic [POLICY_W-1:0] cfg_wr_data = '0;

  // Mirror of the worker table, turn counter and policy
  logic                healthy_tbl [NUM_WORKERS];
  logic [JOBS_W-1:0]   jobs_tbl [NUM_WORKERS];
  logic [TIME_W-1:0]   time_tbl [NUM_WORKERS];
  logic [TURN_W-1:0]   turn_count = '0;
  logic [POLICY_W-1:0] cur_policy = wdsel_pkg::POLICY_RR;

  pick_result_t pending_picks [$];

  bit idle_on = 1'b1;
  bit run_active = 1'b0;
  int mismatch_count = 0;
  int sent_count = 0;
  int pick_count = 0;
  int checked_count = 0;
  int found_count = 0;
  int quiet_cycles = 0;
  int stall_left = 0;

  worker_dispatch_selector_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_worker_id      (in_worker_id),
    .in_worker_healthy (in_worker_healthy),
    .in_active_jobs    (in_active_jobs),
    .in_avg_time_ms    (in_avg_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_chosen_worker (out_chosen_worker),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Weighted score, 32 fraction bits, each term truncated on its own
  function automatic logic [63:0] weight_score(input int idx);
    logic [63:0] jobs_div;
    logic [63:0] time_div;
    jobs_div = 64'(jobs_tbl[idx]) + 64'd1;
    time_div = 64'(time_tbl[idx]) + 64'd1000;
    return (64'd1 << 31) / jobs_div + (64'd300 << 32) / time_div + 64'd858993459;
  endfunction

  // Apply one accepted transaction to the mirror; a pick queues its expected result
  function automatic void predict_dispatch(input logic act, input logic [ID_W-1:0] id,
                                           input logic hl, input logic [JOBS_W-1:0] jobs,
                                           input logic [TIME_W-1:0] ms);
    int unsigned  healthy_count;
    logic [31:0]  target;
    int unsigned  seen;
    logic [63:0]  best_score;
    logic [63:0]  score;
    logic [JOBS_W-1:0] best_jobs;
    logic         have;
    pick_result_t res;
    if (act == wdsel_pkg::ACT_UPDATE) begin
      healthy_tbl[id] = hl;
      jobs_tbl[id] = jobs;
      time_tbl[id] = ms;
      return;
    end
    healthy_count = 0;
    for (int i = 0; i < NUM_WORKERS; i++)
      if (healthy_tbl[i]) healthy_count++;
    res = '0;
    have = 1'b0;
    best_score = '0;
    best_jobs = '0;
    if (healthy_count != 0) begin
      res.found = 1'b1;
      if (cur_policy == wdsel_pkg::POLICY_LEAST) begin
        for (int i = 0; i < NUM_WORKERS; i++) begin
          if (healthy_tbl[i] && (!have || jobs_tbl[i] < best_jobs)) begin
            best_jobs = jobs_tbl[i];
            res.chosen = ID_W'(i);
            have = 1'b1;
          end
        end
      end else if (cur_policy == wdsel_pkg::POLICY_WEIGHT) begin
        for (int i = 0; i < NUM_WORKERS; i++) begin
          if (healthy_tbl[i]) begin
            score = weight_score(i);
            if (!have || score > best_score) begin
              best_score = score;
              res.chosen = ID_W'(i);
              have = 1'b1;
            end
          end
        end
      end else begin
        // round robin, spare code included: only a successful pick advances the turn
        target = turn_count % healthy_count;
        seen = 0;
        for (int i = 0; i < NUM_WORKERS; i++) begin
          if (healthy_tbl[i] && !have) begin
            if (seen == target) begin
              res.chosen = ID_W'(i);
              have = 1'b1;
            end
            seen++;
          end
        end
        turn_count = turn_count + TURN_W'(1);
      end
    end
    pending_picks = {pending_picks, res};
  endfunction

  // Result side: random stall bursts while idling is enabled
  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expected pick
  always @(posedge clk) begin : check_result
    pick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0b worker=%0d",
                 $time, out_found, out_chosen_worker);
        mismatch_count++;
      end else begin
        want = pending_picks.pop_front();
        checked_count++;
        if (out_found) found_count++;
        if (out_found !== want.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, want.found, out_found);
          mismatch_count++;
        end
        if (out_chosen_worker !== want.chosen) begin
          $display("%0t: chosen_worker mismatch, expected %0d, actual %0d",
                   $time, want.chosen, out_chosen_worker);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!run_active || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one transaction, with an optional gap in front, and wait for acceptance
  task automatic send_item(input logic act, input logic [ID_W-1:0] id, input logic hl,
                           input logic [JOBS_W-1:0] jobs, input logic [TIME_W-1:0] ms);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_worker_id <= id;
    in_worker_healthy <= hl;
    in_active_jobs <= jobs;
    in_avg_time_ms <= ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (act == wdsel_pkg::ACT_PICK) pick_count++;
    predict_dispatch(act, id, hl, jobs, ms);
  endtask

  task automatic send_pick();
    send_item(wdsel_pkg::ACT_PICK, ID_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
              JOBS_W'($urandom), TIME_W'($urandom));
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
  endtask

  // Policy write while the block is idle
  task automatic set_policy(input logic [POLICY_W-1:0] pol);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= pol;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_policy = pol;
  endtask

  // Pick on an empty table: nothing found, turn counter held
  task automatic test_no_healthy();
    send_pick();
  endtask

  // Three healthy workers, two at field extremes, four round-robin picks and two on the spare code
  task automatic test_round_robin();
    send_item(wdsel_pkg::ACT_UPDATE, 4'd3, 1'b1, 16'd0, 20'd0);
    send_item(wdsel_pkg::ACT_UPDATE, 4'd12, 1'b1, 16'hFFFF, 20'hFFFFF);
    send_item(wdsel_pkg::ACT_UPDATE, 4'd7, 1'b1, 16'd5, 20'd500);
    repeat (4) send_pick();
    set_policy(POLICY_SPARE);
    repeat (2) send_pick();
  endtask

  // Job-count tie goes to the lower id; an unhealthy entry is skipped
  task automatic test_least_loaded();
    set_policy(wdsel_pkg::POLICY_LEAST);
    send_item(wdsel_pkg::ACT_UPDATE, 4'd15, 1'b1, 16'd0, 20'hFFFFF);
    send_pick();
    send_item(wdsel_pkg::ACT_UPDATE, 4'd3, 1'b0, 16'hFFFF, 20'd0);
    send_pick();
  endtask

  // Weighted pick, then an exact score tie between two entries
  task automatic test_weighted();
    set_policy(wdsel_pkg::POLICY_WEIGHT);
    send_pick();
    send_item(wdsel_pkg::ACT_UPDATE, 4'd7, 1'b1, 16'd0, 20'hFFFFF);
    send_pick();
  endtask

  // Mark everything unhealthy again and pick under each policy
  task automatic test_clear_table();
    send_item(wdsel_pkg::ACT_UPDATE, 4'd7, 1'b0, 16'd1, 20'd1);
    send_item(wdsel_pkg::ACT_UPDATE, 4'd12, 1'b0, 16'd2, 20'd2);
    send_item(wdsel_pkg::ACT_UPDATE, 4'd15, 1'b0, 16'd3, 20'd3);
    send_pick();
    set_policy(wdsel_pkg::POLICY_LEAST);
    send_pick();
    set_policy(wdsel_pkg::POLICY_RR);
    send_pick();
  endtask

  // Random mix of updates and picks under one policy, drained once halfway
  task automatic test_random_phase(input logic [POLICY_W-1:0] pol, input int n_items,
                                   input int health_pct, input bit with_idle);
    logic              act;
    logic [JOBS_W-1:0] jobs;
    logic [TIME_W-1:0] ms;
    set_policy(pol);
    idle_on = with_idle;
    for (int n = 0; n < n_items; n++) begin
      if (n == n_items / 2) wait_drained();
      act = ($urandom_range(0, 9) < 4) ? wdsel_pkg::ACT_PICK : wdsel_pkg::ACT_UPDATE;
      // small values make ties likely, full range covers every bit
      jobs = $urandom_range(0, 1) ? JOBS_W'($urandom_range(0, 3)) : JOBS_W'($urandom);
      case ($urandom_range(0, 2))
        0: ms = TIME_W'($urandom_range(0, 2) * 1000);
        1: ms = TIME_W'($urandom);
        default: ms = $urandom_range(0, 1) ? '0 : '1;
      endcase
      send_item(act, ID_W'($urandom_range(0, 15)),
                1'($urandom_range(0, 99) < health_pct), jobs, ms);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_WORKERS; i++) healthy_tbl[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_active = 1'b1;

    test_no_healthy();
    test_round_robin();
    test_least_loaded();
    test_weighted();
    test_clear_table();

    test_random_phase(wdsel_pkg::POLICY_RR, 105, 50, 1'b1);
    test_random_phase(wdsel_pkg::POLICY_LEAST, 105, 40, 1'b1);
    test_random_phase(wdsel_pkg::POLICY_WEIGHT, 105, 50, 1'b1);
    test_random_phase(POLICY_SPARE, 105, 30, 1'b1);
    test_random_phase(wdsel_pkg::POLICY_WEIGHT, 105, 70, 1'b1);
    test_random_phase(wdsel_pkg::POLICY_LEAST, 105, 60, 1'b1);
    test_random_phase(wdsel_pkg::POLICY_RR, 105, 45, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input transactions (%0d picks) across all four policy codes",
             sent_count, pick_count);
    $display("%0d results checked, %0d with a worker found, %0d mismatches",
             checked_count, found_count, mismatch_count);
    if (mismatch_count == 0 && pending_picks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wdsel_pkg.sv
rtl/wdsel_ram.sv
rtl/wdsel_div.sv
rtl/wdsel_dp.sv
rtl/wdsel_ctrl.sv
rtl/worker_dispatch_selector_unit.sv
test/tb.sv
